>>> design/i2cmbe_pkg.sv
// package for the i2c master bit engine
// command codes and field widths; no dependencies
`timescale 1ns / 1ps

package i2cmbe_pkg;

   localparam int KIND_W  = 3;
   localparam int BYTE_W  = 8;
   localparam int PHASE_W = 2;
   localparam int BIT_W   = 3;

   localparam logic [KIND_W-1:0] KIND_START    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_STOP     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SEND_ACK = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RECV_ACK = 3'd5;

   localparam logic [PHASE_W-1:0] PH_0 = 2'd0;
   localparam logic [PHASE_W-1:0] PH_1 = 2'd1;
   localparam logic [PHASE_W-1:0] PH_2 = 2'd2;
   localparam logic [PHASE_W-1:0] PH_3 = 2'd3;

   localparam logic [BIT_W-1:0] BIT_LAST = 3'd7;

   typedef logic [BYTE_W-1:0] byte_type;

endpackage

>>> design/i2c_master_bit_engine.sv
// i2c master bit engine top level: one command in, one pin write out per cycle while rsp_ is not stalled
// depends on i2cmbe_pkg
`timescale 1ns / 1ps
//
//  channel  dir  handshake              payload
//  req_     in   req_valid / req_ready  kind, tx_byte, ack_level, line_levels
//  rsp_     out  rsp_valid / rsp_ready  scl, sda, read_value, last
//
//  a request is taken while idle, then one pin write per cycle while the output
//  register drains: start 4, stop 3, write 24, read 17, acks 3 pin writes; an
//  unknown command is dropped in its accept cycle
//  synchronous reset puts both lines high and the engine idle
//  a stalled rsp_ holds the engine; the next request is taken once the last
//  pin write of a command is in the output register

module i2c_master_bit_engine
   import i2cmbe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [BYTE_W-1:0] req_tx_byte,
   input  logic              req_ack_level,
   input  logic [BYTE_W-1:0] req_line_levels,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_scl,
   output logic              rsp_sda,
   output logic [BYTE_W-1:0] rsp_read_value,
   output logic              rsp_last
);

   logic               busy_ff, busy_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   byte_type           tx_ff, tx_in;
   byte_type           lines_ff, lines_in;
   byte_type           val_ff, val_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_last_ff, rsp_last_in;
   byte_type           rsp_value_ff, rsp_value_in;

   logic req_fire, adv, last_now, sample, known_kind;
   byte_type val_next;

   assign known_kind = (req_kind == KIND_START) || (req_kind == KIND_STOP) ||
                       (req_kind == KIND_WRITE) || (req_kind == KIND_READ) ||
                       (req_kind == KIND_SEND_ACK) || (req_kind == KIND_RECV_ACK);
   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;
   assign adv       = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign val_next  = {val_ff[BYTE_W-2:0], lines_ff[BYTE_W-1]};

   always_comb begin
      busy_in      = busy_ff;
      kind_in      = kind_ff;
      phase_in     = phase_ff;
      bit_in       = bit_ff;
      tx_in        = tx_ff;
      lines_in     = lines_ff;
      val_in       = val_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      last_now     = 1'b0;
      sample       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_last_in  = rsp_last_ff;
      rsp_value_in = rsp_value_ff;

      if (adv) begin
         phase_in = phase_ff + 2'd1;
         unique case (kind_ff)
            KIND_START: begin
               unique case (phase_ff)
                  PH_0: sda_in = 1'b1;
                  PH_1: scl_in = 1'b1;
                  PH_2: sda_in = 1'b0;
                  PH_3: begin
                     scl_in   = 1'b0;
                     last_now = 1'b1;
                  end
                  default: ;
               endcase
            end
            KIND_STOP: begin
               unique case (phase_ff)
                  PH_0: sda_in = 1'b0;
                  PH_1: scl_in = 1'b1;
                  default: begin
                     sda_in   = 1'b1;
                     last_now = 1'b1;
                  end
               endcase
            end
            default: begin
               // write, read and both acks share the three-phase bit slot; read skips phase 0 after its first bit
               unique case (phase_ff)
                  PH_0: begin
                     if ((kind_ff == KIND_WRITE) || (kind_ff == KIND_SEND_ACK)) begin
                        sda_in = tx_ff[BYTE_W-1];
                     end else begin
                        sda_in = 1'b1;
                     end
                  end
                  PH_1: begin
                     scl_in = 1'b1;
                     sample = 1'b1;
                  end
                  default: begin
                     scl_in = 1'b0;
                     bit_in = bit_ff + 3'd1;
                     tx_in  = {tx_ff[BYTE_W-2:0], 1'b0};
                     if (kind_ff == KIND_READ) begin
                        phase_in = PH_1;
                     end else begin
                        phase_in = PH_0;
                     end
                     last_now = (kind_ff == KIND_SEND_ACK) ||
                                (kind_ff == KIND_RECV_ACK) || (bit_ff == BIT_LAST);
                  end
               endcase
            end
         endcase

         if (sample) begin
            val_in   = val_next;
            lines_in = {lines_ff[BYTE_W-2:0], 1'b0};
         end

         rsp_valid_in = 1'b1;
         rsp_last_in  = last_now;
         rsp_value_in = '0;
         if (last_now) begin
            busy_in = 1'b0;
            if (kind_ff == KIND_READ) begin
               rsp_value_in = val_ff;
            end else if (kind_ff == KIND_RECV_ACK) begin
               rsp_value_in = {{(BYTE_W-1){1'b0}}, val_ff[0]};
            end
         end
      end

      if (req_fire) begin
         busy_in  = known_kind;
         kind_in  = req_kind;
         phase_in = PH_0;
         bit_in   = '0;
         lines_in = req_line_levels;
         val_in   = '0;
         if (req_kind == KIND_SEND_ACK) begin
            tx_in = {req_ack_level, {(BYTE_W-1){1'b0}}};
         end else begin
            tx_in = req_tx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_0;
         bit_ff       <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         bit_ff       <= bit_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      tx_ff        <= tx_in;
      lines_ff     <= lines_in;
      val_ff       <= val_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl        = scl_ff;
   assign rsp_sda        = sda_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   a_busy_known_kind: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (kind_ff == KIND_START) || (kind_ff == KIND_STOP) ||
                  (kind_ff == KIND_WRITE) || (kind_ff == KIND_READ) ||
                  (kind_ff == KIND_SEND_ACK) || (kind_ff == KIND_RECV_ACK))
      else $error("engine busy on an unknown command");

   a_last_ends_cmd: assert property (@(posedge clock) disable iff (reset)
      (adv && last_now) |=> !busy_ff && rsp_valid_ff && rsp_last_ff)
      else $error("final pin write did not end the command");

   a_value_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_value_ff == '0))
      else $error("read value on an intermediate pin write");

   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && !req_fire) |=> !(rsp_valid_ff && !$past(rsp_valid_ff)))
      else $error("pin write emitted while idle");
`endif

endmodule

>>> verif/tb_i2c_master_bit_engine.sv
// testbench for the i2c master bit engine: random and directed bus commands,
// every pin write checked against a local line-level predictor
// depends on i2cmbe_pkg and i2c_master_bit_engine
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine
   import i2cmbe_pkg::*;
();

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_TARGET = 470;
   localparam int DRAIN_CYCLES  = 48;

   localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

   typedef struct packed {
      logic     scl;
      logic     sda;
      byte_type read_value;
      logic     last;
   } pin_write_type;

   class pin_write_scoreboard;
      pin_write_type pending_writes[$];
      int            errors;
      logic          scl_now;
      logic          sda_now;

      function new();
         errors  = 0;
         scl_now = 1'b1;
         sda_now = 1'b1;
      endfunction

      function void record_pin();
         pin_write_type w;
         w = '0;
         w.scl = scl_now;
         w.sda = sda_now;
         pending_writes.push_back(w);
      endfunction

      function void drive_scl(logic v);
         scl_now = v;
         record_pin();
      endfunction

      function void drive_sda(logic v);
         sda_now = v;
         record_pin();
      endfunction

      // expected pin writes of one accepted request
      function void add_command(logic [KIND_W-1:0] kind, byte_type tx, logic ack,
                                byte_type lines);
         byte_type      value;
         int            first_new;
         pin_write_type w;
         value = '0;
         first_new = pending_writes.size();
         case (kind)
            KIND_START: begin
               drive_sda(1'b1);
               drive_scl(1'b1);
               drive_sda(1'b0);
               drive_scl(1'b0);
            end
            KIND_STOP: begin
               drive_sda(1'b0);
               drive_scl(1'b1);
               drive_sda(1'b1);
            end
            KIND_WRITE: begin
               for (int i = BYTE_W - 1; i >= 0; i--) begin
                  drive_sda(tx[i]);
                  drive_scl(1'b1);
                  drive_scl(1'b0);
               end
            end
            KIND_READ: begin
               drive_sda(1'b1);
               for (int i = BYTE_W - 1; i >= 0; i--) begin
                  drive_scl(1'b1);
                  value[i] = lines[i];
                  drive_scl(1'b0);
               end
            end
            KIND_SEND_ACK: begin
               drive_sda(ack);
               drive_scl(1'b1);
               drive_scl(1'b0);
            end
            KIND_RECV_ACK: begin
               drive_sda(1'b1);
               drive_scl(1'b1);
               value = {7'b0, lines[BYTE_W-1]};
               drive_scl(1'b0);
            end
            default: ;
         endcase
         if (pending_writes.size() > first_new) begin
            w = pending_writes.pop_back();
            w.read_value = value;
            w.last = 1'b1;
            pending_writes.push_back(w);
         end
      endfunction

      function void check_pin_write(logic scl, logic sda, byte_type rv, logic last);
         pin_write_type want;
         if (pending_writes.size() == 0) begin
            $error("pin write with none pending: scl %0d sda %0d read_value %02h last %0d",
                   scl, sda, rv, last);
            errors++;
            return;
         end
         want = pending_writes.pop_front();
         if (scl !== want.scl) begin
            $error("scl expected %0d actual %0d", want.scl, scl);
            errors++;
         end
         if (sda !== want.sda) begin
            $error("sda expected %0d actual %0d", want.sda, sda);
            errors++;
         end
         if (rv !== want.read_value) begin
            $error("read_value expected %02h actual %02h", want.read_value, rv);
            errors++;
         end
         if (last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [KIND_W-1:0] req_kind;
   logic [BYTE_W-1:0] req_tx_byte;
   logic              req_ack_level;
   logic [BYTE_W-1:0] req_line_levels;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_scl;
   logic              rsp_sda;
   logic [BYTE_W-1:0] rsp_read_value;
   logic              rsp_last;

   pin_write_scoreboard board;
   bit                  idle_on;
   int                  commands_sent;
   int                  cycles;

   i2c_master_bit_engine u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_tx_byte     (req_tx_byte),
      .req_ack_level   (req_ack_level),
      .req_line_levels (req_line_levels),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_scl         (rsp_scl),
      .rsp_sda         (rsp_sda),
      .rsp_read_value  (rsp_read_value),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic issue_request(logic [KIND_W-1:0] kind, byte_type tx, logic ack,
                                byte_type lines);
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_tx_byte     <= tx;
      req_ack_level   <= ack;
      req_line_levels <= lines;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.add_command(kind, tx, ack, lines);
      if (kind <= KIND_RECV_ACK) commands_sent++;
   endtask

   // result side
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = idle_on ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         board.check_pin_write(rsp_scl, rsp_sda, rsp_read_value, rsp_last);
      end
   end

   initial begin
      int n_data;
      board = new();
      idle_on = 1'b1;
      commands_sent = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_kind        <= KIND_START;
      req_tx_byte     <= '0;
      req_ack_level   <= 1'b0;
      req_line_levels <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed
      issue_request(KIND_START,    8'h00, 1'b0, 8'h00);
      issue_request(KIND_WRITE,    8'h00, 1'b0, 8'h00);
      issue_request(KIND_WRITE,    8'hFF, 1'b1, 8'hFF);
      issue_request(KIND_WRITE,    8'hA5, 1'b0, 8'h5A);
      issue_request(KIND_WRITE,    8'h5A, 1'b1, 8'hA5);
      issue_request(KIND_RECV_ACK, 8'hFF, 1'b1, 8'h80);
      issue_request(KIND_RECV_ACK, 8'h00, 1'b0, 8'h7F);
      issue_request(KIND_READ,     8'hFF, 1'b1, 8'h00);
      issue_request(KIND_READ,     8'h00, 1'b0, 8'hFF);
      issue_request(KIND_READ,     8'h3C, 1'b1, 8'h96);
      issue_request(KIND_SEND_ACK, 8'hFF, 1'b0, 8'hFF);
      issue_request(KIND_SEND_ACK, 8'h00, 1'b1, 8'h00);
      issue_request(KIND_SPARE_6,  8'hFF, 1'b1, 8'hFF);
      issue_request(KIND_STOP,     8'hFF, 1'b1, 8'hFF);
      issue_request(KIND_STOP,     8'h00, 1'b0, 8'h00);
      issue_request(KIND_SPARE_7,  8'h00, 1'b0, 8'h00);
      issue_request(KIND_START,    8'hFF, 1'b1, 8'hFF);
      issue_request(KIND_START,    8'h00, 1'b0, 8'h00);
      issue_request(KIND_SEND_ACK, 8'h55, 1'b1, 8'hAA);
      issue_request(KIND_STOP,     8'hAA, 1'b0, 8'h55);

      // random: mostly whole transfers, some loose commands
      while (commands_sent < RANDOM_TARGET) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) < 8) begin
            issue_request(KIND_START, BYTE_W'($urandom), 1'($urandom),
                          BYTE_W'($urandom));
            issue_request(KIND_WRITE, BYTE_W'($urandom), 1'($urandom),
                          BYTE_W'($urandom));
            issue_request(KIND_RECV_ACK, BYTE_W'($urandom), 1'($urandom),
                          BYTE_W'($urandom));
            n_data = $urandom_range(0, 4);
            for (int i = 0; i < n_data; i++) begin
               if ($urandom_range(0, 1)) begin
                  issue_request(KIND_WRITE, BYTE_W'($urandom), 1'($urandom),
                                BYTE_W'($urandom));
                  issue_request(KIND_RECV_ACK, BYTE_W'($urandom), 1'($urandom),
                                BYTE_W'($urandom));
               end else begin
                  issue_request(KIND_READ, BYTE_W'($urandom), 1'($urandom),
                                BYTE_W'($urandom));
                  issue_request(KIND_SEND_ACK, BYTE_W'($urandom), 1'($urandom),
                                BYTE_W'($urandom));
               end
            end
            if ($urandom_range(0, 9) != 0)
               issue_request(KIND_STOP, BYTE_W'($urandom), 1'($urandom),
                             BYTE_W'($urandom));
         end else begin
            n_data = $urandom_range(1, 4);
            for (int i = 0; i < n_data; i++)
               issue_request(KIND_W'($urandom_range(0, 7)), BYTE_W'($urandom),
                             1'($urandom), BYTE_W'($urandom));
         end
      end
      req_valid <= 1'b0;

      while (board.pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_writes.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> sim.f
design/i2cmbe_pkg.sv
design/i2c_master_bit_engine.sv
verif/tb_i2c_master_bit_engine.sv
